FILE: sv/slp_pkg.sv
// Shared types, constants, saturation helper and sigmoid table generation for the sparse logistic inference block.
`default_nettype none

package slp_pkg;

  localparam int POS_W  = 10;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 40;
  localparam int OFF_W  = 28;
  localparam int PROB_W = 16;

  localparam int DEF_VECTOR_SIZE     = 1024;
  localparam int DEF_SIGMOID_ENTRIES = 256;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_ELEM  = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Feature element or sample end entering the multiply-accumulate pipeline.
  typedef struct packed {
    logic                    vld;
    logic                    use_w;
    logic                    close;
    logic signed [VAL_W-1:0] value;
  } elem_t;

  // Closed sample handed from the accumulator to the sigmoid stages.
  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] sum;
  } close_t;

  // Saturate a sum that has grown by one bit back to the accumulator width.
  function automatic logic signed [ACC_W-1:0] slp_sat(input logic signed [ACC_W:0] x);
    logic signed [ACC_W-1:0] r;
    if (x[ACC_W] != x[ACC_W-1]) begin
      r = x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = x[ACC_W-1:0];
    end
    return r;
  endfunction

  // Long division by shift and subtract, used only while the table is elaborated.
  function automatic longint unsigned slp_udiv(input longint unsigned a,
                                               input longint unsigned b);
    logic [64:0]     rem;
    longint unsigned q;
    rem = '0;
    q   = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], a[k]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // One sigmoid table entry, taken at the midpoint of bin i out of ent bins over [-8, 8).
  function automatic logic [PROB_W-1:0] slp_sig_entry(input int unsigned i,
                                                      input int unsigned ent);
    longint          m;
    longint unsigned mag;
    longint unsigned t;
    longint unsigned f;
    longint unsigned term;
    longint unsigned e;
    longint unsigned d;
    longint unsigned p;
    longint unsigned one;
    one  = 64'd1 << 32;
    m    = longint'(i) * 2 + 1 - longint'(ent);
    mag  = (m < 0) ? longint'(-m) : longint'(m);
    t    = slp_udiv(mag << 35, longint'(ent));
    f    = t >> 4;
    term = one;
    e    = one;
    for (int n = 1; n <= 20; n++) begin
      term = slp_udiv((term * f) >> 32, longint'(n));
      if (n % 2 == 1) begin
        e = e - term;
      end else begin
        e = e + term;
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (e < one) begin
        e = (e * e + 64'h8000_0000) >> 32;
      end
    end
    d = one + e;
    if (m >= 0) begin
      p = slp_udiv((64'd1 << 48) + (d >> 1), d);
    end else begin
      p = slp_udiv((e << 16) + (d >> 1), d);
    end
    if (p > 64'd65535) begin
      p = 64'd65535;
    end
    return p[PROB_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/slp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module slp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [$clog2(DEPTH)-1:0]  waddr,
  input  wire  [WIDTH-1:0]          wdata,
  input  wire                       re,
  input  wire  [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/slp_mac.sv
// Multiply-accumulate pipeline: weight times value, summed per sample with saturation.
`default_nettype none

module slp_mac
  import slp_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     en,
  input  elem_t                   elem,
  input  wire  [VAL_W-1:0]        weight,
  output close_t                  closed
);

  // Stage 1: weight arrives from the RAM alongside the registered element.
  logic                     s1_vld_r;
  logic                     s1_use_w_r;
  logic                     s1_close_r;
  logic signed [VAL_W-1:0]  s1_value_r;

  // Stage 2: registered product.
  logic                     s2_vld_r;
  logic                     s2_close_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [PROD_W-1:0] s2_prod_nxt;

  // Stage 3: running score and the closed sample.
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  sum;
  logic                     s3_vld_r;
  logic signed [ACC_W-1:0]  s3_sum_r;

  always_comb begin
    if (s1_use_w_r) begin
      s2_prod_nxt = $signed(weight) * s1_value_r;
    end else begin
      s2_prod_nxt = '0;
    end
  end

  assign sum = slp_sat({acc_r[ACC_W-1], acc_r}
                       + {{(ACC_W+1-PROD_W){s2_prod_r[PROD_W-1]}}, s2_prod_r});

  always_comb begin
    acc_nxt = acc_r;
    if (s2_vld_r) begin
      acc_nxt = s2_close_r ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      acc_r    <= '0;
    end else if (en) begin
      s1_vld_r <= elem.vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && s2_close_r;
      acc_r    <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_use_w_r <= elem.use_w;
      s1_close_r <= elem.close;
      s1_value_r <= elem.value;
      s2_close_r <= s1_close_r;
      s2_prod_r  <= s2_prod_nxt;
      s3_sum_r   <= sum;
    end
  end

  assign closed.vld = s3_vld_r;
  assign closed.sum = s3_sum_r;

endmodule

`default_nettype wire

FILE: sv/slp_sigmoid.sv
// Bias addition, clamping, sigmoid table lookup and the output register.
`default_nettype none

module slp_sigmoid
  import slp_pkg::*;
#(
  parameter int SIGMOID_ENTRIES = DEF_SIGMOID_ENTRIES
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  close_t                   closed,
  input  wire  signed [VAL_W-1:0]  bias,
  output logic                     hold,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [PROB_W-1:0]        out_prob,
  output logic                     out_label
);

  localparam int IDX_W = $clog2(SIGMOID_ENTRIES);
  localparam int ENT_W = $clog2(SIGMOID_ENTRIES + 1);
  localparam int MUL_W = OFF_W + ENT_W;

  logic [PROB_W-1:0] sig_rom [SIGMOID_ENTRIES];

  for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_rom
    localparam logic [PROB_W-1:0] ENTRY = slp_sig_entry(g, SIGMOID_ENTRIES);
    assign sig_rom[g] = ENTRY;
  end

  // Stage 4: score with bias.
  logic                    s4_vld_r;
  logic signed [ACC_W-1:0] s4_score_r;
  logic signed [ACC_W-1:0] s4_score_nxt;

  // Stage 5: label and table index.
  logic                    s5_vld_r;
  logic                    s5_label_r;
  logic [IDX_W-1:0]        s5_idx_r;
  logic [OFF_W-1:0]        clamped;
  logic [OFF_W-1:0]        offset;
  logic [MUL_W-1:0]        idx_prod;
  logic                    label_nxt;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [PROB_W-1:0]       out_prob_r;
  logic                    out_label_r;

  assign s4_score_nxt = slp_sat({closed.sum[ACC_W-1], closed.sum}
                                + {{(ACC_W+1-VAL_W-12){bias[VAL_W-1]}}, bias, 12'b0});

  always_comb begin
    priority if (!s4_score_r[ACC_W-1] && (|s4_score_r[ACC_W-2:OFF_W-1])) begin
      clamped = {1'b0, {(OFF_W-1){1'b1}}};
    end else if (s4_score_r[ACC_W-1] && !(&s4_score_r[ACC_W-2:OFF_W-1])) begin
      clamped = {1'b1, {(OFF_W-1){1'b0}}};
    end else begin
      clamped = s4_score_r[OFF_W-1:0];
    end
  end

  // Adding half the range just flips the sign bit of the clamped score.
  assign offset    = {~clamped[OFF_W-1], clamped[OFF_W-2:0]};
  assign idx_prod  = MUL_W'(offset) * MUL_W'(SIGMOID_ENTRIES);
  assign label_nxt = !s4_score_r[ACC_W-1] && (|s4_score_r[ACC_W-2:0]);

  // Freeze when a new result reaches the tail while the held one is not taken.
  assign hold = s5_vld_r && out_valid_r && !out_ready;

  assign out_valid_nxt = s5_vld_r ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= en ? out_valid_nxt : out_valid_r;
      if (en) begin
        s4_vld_r <= closed.vld;
        s5_vld_r <= s4_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_score_r <= s4_score_nxt;
      s5_label_r <= label_nxt;
      s5_idx_r   <= idx_prod[OFF_W +: IDX_W];
      if (s5_vld_r) begin
        out_prob_r  <= sig_rom[s5_idx_r];
        out_label_r <= s5_label_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_prob  = out_prob_r;
  assign out_label = out_label_r;

endmodule

`default_nettype wire

FILE: sv/sparse_logistic_inference.sv
// Top level of the sparse logistic-regression inference block.
`default_nettype none

// Sparse logistic-regression inference. Weight items (operation 0) load a
// Q4.12 weight into the weight RAM; feature elements (operation 1) read the
// weight at their position and add weight times value into a saturating
// Q16.24 score; an element with tlast set, or an end item (operation 2),
// closes the sample. A closed sample has the configured bias added and gives
// one result item: a Q0.16 sigmoid probability from a constant table over the
// score clamped to [-8, 8), and a label that is 1 when the score is above
// zero. Operation 3 is dropped. The block takes one item every cycle while
// it is not frozen. The RAM read for the item closing a sample is launched
// at the edge that accepts it; then come multiply, accumulate, bias add,
// clamp and index, and the table lookup into the output register.
// The accumulator is a single register fed back into its adder, so
// consecutive elements of a sample need no interlock. The whole
// pipeline freezes, and in_tready falls, only in a cycle where a finished
// result is still held at the output and a further result reaches the last
// stage; otherwise items keep flowing while the output waits. There is no
// clearing pass after reset: weights read before they are written are
// undefined. The bias is to be written through the cfg port only while the
// block is idle (the block does not enforce it); the port is always ready.

module sparse_logistic_inference
  import slp_pkg::*;
#(
  parameter int VECTOR_SIZE     = DEF_VECTOR_SIZE,
  parameter int SIGMOID_ENTRIES = DEF_SIGMOID_ENTRIES
) (
  input  wire         clk,
  input  wire         rst_n,
  // Input items.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [9:0] position, [25:10] value, [31:26] zero
  input  wire  [1:0]  in_tuser,   // [1:0] operation
  input  wire         in_tlast,   // last element of a sample
  // Result items.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [15:0] probability, [16] label, [23:17] zero
  // Bias register write.
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data    // bias_term, signed Q4.12
);

  localparam int AW = $clog2(VECTOR_SIZE);

  logic                    en;
  logic                    hold;
  logic                    accept;
  op_t                     op;
  logic [POS_W-1:0]        in_pos;
  logic signed [VAL_W-1:0] in_val;
  logic                    in_rng;
  logic [POS_W+AW-1:0]     pos_ext;
  logic [AW-1:0]           addr;
  logic                    ram_we;
  logic                    ram_re;
  logic [VAL_W-1:0]        weight;
  elem_t                   elem;
  close_t                  closed;
  logic signed [VAL_W-1:0] bias_r;
  logic                    res_valid;
  logic [PROB_W-1:0]       res_prob;
  logic                    res_label;

  assign en        = !hold;
  assign in_tready = en;
  assign accept    = in_tvalid && in_tready;

  assign op      = op_t'(in_tuser);
  assign in_pos  = in_tdata[POS_W-1:0];
  assign in_val  = $signed(in_tdata[POS_W +: VAL_W]);
  assign in_rng  = 32'(in_pos) < VECTOR_SIZE;
  assign pos_ext = {{AW{1'b0}}, in_pos};
  assign addr    = pos_ext[AW-1:0];

  // Writes and reads of the weight RAM come from different items, so they
  // never meet on the same edge; a read accepted after a write sees it.
  assign ram_we = accept && (op == OP_WRITE) && in_rng;
  assign ram_re = accept && (op == OP_ELEM);

  always_comb begin
    elem.vld   = 1'b0;
    elem.use_w = 1'b0;
    elem.close = 1'b0;
    elem.value = in_val;
    unique case (op)
      OP_ELEM: begin
        elem.vld   = accept;
        elem.use_w = in_rng;
        elem.close = in_tlast;
      end
      OP_END: begin
        elem.vld   = accept;
        elem.close = 1'b1;
      end
      OP_WRITE, OP_NONE: begin
        elem.vld = 1'b0;
      end
      default: begin
        elem.vld = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      bias_r <= $signed(cfg_data);
    end
  end

  slp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VECTOR_SIZE)
  ) u_weights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (in_tdata[POS_W +: VAL_W]),
    .re    (ram_re),
    .raddr (addr),
    .rdata (weight)
  );

  slp_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .elem   (elem),
    .weight (weight),
    .closed (closed)
  );

  slp_sigmoid #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_sigmoid (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .closed    (closed),
    .bias      (bias_r),
    .hold      (hold),
    .out_valid (res_valid),
    .out_ready (out_tready),
    .out_prob  (res_prob),
    .out_label (res_label)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {7'b0, res_label, res_prob};

endmodule

`default_nettype wire
